/* rtl/c2s_pkg.sv */
// types, constants and helper functions shared by the cartesian to spherical pipeline
package c2s_pkg;

    localparam int COORD_BITS = 24;
    localparam int ANGLE_BITS = 16;
    localparam int MAG_W      = 2 * COORD_BITS;
    // digit steps of the root unit, enough for a radicand below 2^60
    localparam int SQ_STEPS   = 30;
    localparam int RAD_W      = 2 * SQ_STEPS;
    localparam int REM_W      = SQ_STEPS + 4;
    localparam int ROOT_W     = SQ_STEPS + 1;
    // rotation datapath width, covers gain and growth of normalized vectors
    localparam int CW         = 36;
    localparam int ANG_W      = 32;
    localparam int SHIFT_W    = 5;
    // target of the normalizing shift, radicand lands in [2^58, 2^60)
    localparam int NORM_TOP   = 59;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } t_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] radius;
        logic [ANGLE_BITS-1:0] azimuth;
        logic [ANGLE_BITS-1:0] polar_angle;
        logic                  zero_radius;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] az_x;
        logic signed [CW-1:0] az_y;
        logic signed [CW-1:0] pol_x;
        logic                 zero;
        logic                 plane_zero;
    } t_side;

    typedef struct packed {
        logic [COORD_BITS-1:0] radius;
        logic                  zero;
        logic                  plane_zero;
    } t_tail;

    // atan(2^-i) in turns, 2^32 is a full turn
    function automatic logic [ANG_W-1:0] atan_turns(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // pairs of bit positions to shift a nonzero magnitude into [2^58, 2^60)
    function automatic logic [SHIFT_W-1:0] norm_shift(input logic [MAG_W-1:0] m);
        logic [5:0] p;
        logic [5:0] k;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (m[i]) p = 6'(i);
        end
        k = (6'(NORM_TOP) - p) >> 1;
        return k[SHIFT_W-1:0];
    endfunction

endpackage

/* rtl/c2s_front.sv */
// front end: magnitudes, squares, sums and normalizing shifts
module c2s_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  c2s_pkg::t_in                        i_data,
    output logic                                o_valid,
    output c2s_pkg::t_side                      o_side,
    output logic [c2s_pkg::RAD_W-1:0]           o_rad_n,
    output logic [c2s_pkg::RAD_W-1:0]           o_pol_n
);

    localparam int CB = c2s_pkg::COORD_BITS;
    localparam int MW = c2s_pkg::MAG_W;
    localparam int CW = c2s_pkg::CW;
    localparam int RW = c2s_pkg::RAD_W;

    logic [5:0] r_vld;

    logic signed [CB-1:0] r1_x, r1_y, r1_z, r2_x, r2_y, r2_z, r3_x, r3_y, r3_z;
    logic signed [CB-1:0] r4_x, r4_y, r4_z, r5_x, r5_y, r5_z;
    logic [CB-1:0] r1_ax, r1_ay, r1_az;
    logic [MW-1:0] r2_xx, r2_yy, r2_zz, r3_plane, r3_zz;
    logic [MW-1:0] r4_total, r4_plane, r4_max, r5_total, r5_plane;
    logic          r4_zero, r4_pzero, r5_zero, r5_pzero;
    logic [c2s_pkg::SHIFT_W-1:0] r5_k1, r5_k2;
    c2s_pkg::t_side       r_side;
    logic [RW-1:0]        r_rad_n, r_pol_n;

    logic [CB-1:0] n_ax, n_ay, n_az;
    logic signed [CW-1:0] sx, sy, sz;

    assign n_ax = i_data.coord_x[CB-1] ? (~i_data.coord_x + 1'b1) : i_data.coord_x;
    assign n_ay = i_data.coord_y[CB-1] ? (~i_data.coord_y + 1'b1) : i_data.coord_y;
    assign n_az = i_data.coord_z[CB-1] ? (~i_data.coord_z + 1'b1) : i_data.coord_z;

    assign sx = {{(CW-CB){r5_x[CB-1]}}, r5_x};
    assign sy = {{(CW-CB){r5_y[CB-1]}}, r5_y};
    assign sz = {{(CW-CB){r5_z[CB-1]}}, r5_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
        if (i_en) begin
            r1_x  <= i_data.coord_x;
            r1_y  <= i_data.coord_y;
            r1_z  <= i_data.coord_z;
            r1_ax <= n_ax;
            r1_ay <= n_ay;
            r1_az <= n_az;

            r2_xx <= r1_ax * r1_ax;
            r2_yy <= r1_ay * r1_ay;
            r2_zz <= r1_az * r1_az;
            r2_x  <= r1_x;
            r2_y  <= r1_y;
            r2_z  <= r1_z;

            r3_plane <= r2_xx + r2_yy;
            r3_zz    <= r2_zz;
            r3_x     <= r2_x;
            r3_y     <= r2_y;
            r3_z     <= r2_z;

            r4_total <= r3_plane + r3_zz;
            r4_plane <= r3_plane;
            r4_max   <= (r3_plane > r3_zz) ? r3_plane : r3_zz;
            r4_pzero <= (r3_plane == '0);
            r4_zero  <= (r3_plane == '0) && (r3_zz == '0);
            r4_x     <= r3_x;
            r4_y     <= r3_y;
            r4_z     <= r3_z;

            r5_k1    <= c2s_pkg::norm_shift(r4_plane);
            r5_k2    <= c2s_pkg::norm_shift(r4_max);
            r5_total <= r4_total;
            r5_plane <= r4_plane;
            r5_zero  <= r4_zero;
            r5_pzero <= r4_pzero;
            r5_x     <= r4_x;
            r5_y     <= r4_y;
            r5_z     <= r4_z;

            r_side.az_x       <= sx <<< r5_k1;
            r_side.az_y       <= sy <<< r5_k1;
            r_side.pol_x      <= sz <<< r5_k2;
            r_side.zero       <= r5_zero;
            r_side.plane_zero <= r5_pzero;
            r_rad_n <= {{(RW-MW){1'b0}}, r5_total};
            r_pol_n <= {{(RW-MW){1'b0}}, r5_plane} << {r5_k2, 1'b0};
        end
    end

    assign o_valid = r_vld[5];
    assign o_side  = r_side;
    assign o_rad_n = r_rad_n;
    assign o_pol_n = r_pol_n;

endmodule

/* rtl/c2s_sqrt.sv */
// two-lane digit-by-digit square root pipeline with round to nearest
module c2s_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  c2s_pkg::t_side                    i_side,
    input  logic [c2s_pkg::RAD_W-1:0]         i_rad_n,
    input  logic [c2s_pkg::RAD_W-1:0]         i_pol_n,
    output logic                              o_valid,
    output c2s_pkg::t_side                    o_side,
    output logic [c2s_pkg::ROOT_W-1:0]        o_rad_root,
    output logic [c2s_pkg::ROOT_W-1:0]        o_pol_root
);

    localparam int ST = c2s_pkg::SQ_STEPS;
    localparam int RW = c2s_pkg::RAD_W;
    localparam int MW = c2s_pkg::REM_W;
    localparam int OW = c2s_pkg::ROOT_W;

    logic [MW-1:0]  r_rem  [ST][2];
    logic [ST-1:0]  r_root [ST][2];
    logic [RW-1:0]  r_n    [ST][2];
    c2s_pkg::t_side r_side [ST];
    logic [ST-1:0]  r_vld;

    logic [OW-1:0]  r_out_rad, r_out_pol;
    c2s_pkg::t_side r_out_side;
    logic           r_out_vld;

    genvar s, l;
    generate
        for (s = 0; s < ST; s++) begin : g_st
            logic [MW-1:0] rem_i  [2];
            logic [ST-1:0] root_i [2];
            logic [RW-1:0] n_i    [2];
            c2s_pkg::t_side side_i;
            logic           vld_i;
            if (s == 0) begin : g_first
                assign rem_i[0]  = '0;
                assign rem_i[1]  = '0;
                assign root_i[0] = '0;
                assign root_i[1] = '0;
                assign n_i[0]    = i_rad_n;
                assign n_i[1]    = i_pol_n;
                assign side_i    = i_side;
                assign vld_i     = i_valid;
            end else begin : g_next
                assign rem_i[0]  = r_rem[s-1][0];
                assign rem_i[1]  = r_rem[s-1][1];
                assign root_i[0] = r_root[s-1][0];
                assign root_i[1] = r_root[s-1][1];
                assign n_i[0]    = r_n[s-1][0];
                assign n_i[1]    = r_n[s-1][1];
                assign side_i    = r_side[s-1];
                assign vld_i     = r_vld[s-1];
            end
            for (l = 0; l < 2; l++) begin : g_lane
                logic [MW-1:0] sh, trial;
                assign sh    = {rem_i[l][MW-3:0], n_i[l][RW-1 -: 2]};
                assign trial = {{(MW-ST-2){1'b0}}, root_i[l], 2'b01};
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        if (sh >= trial) begin
                            r_rem[s][l]  <= sh - trial;
                            r_root[s][l] <= {root_i[l][ST-2:0], 1'b1};
                        end else begin
                            r_rem[s][l]  <= sh;
                            r_root[s][l] <= {root_i[l][ST-2:0], 1'b0};
                        end
                        r_n[s][l] <= {n_i[l][RW-3:0], 2'b00};
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= vld_i;
                end
                if (i_en) begin
                    r_side[s] <= side_i;
                end
            end
        end
    endgenerate

    // remainder above the root means the true root is past the half step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[ST-1];
        end
        if (i_en) begin
            r_out_rad  <= {1'b0, r_root[ST-1][0]}
                + OW'(r_rem[ST-1][0] > {{(MW-ST){1'b0}}, r_root[ST-1][0]});
            r_out_pol  <= {1'b0, r_root[ST-1][1]}
                + OW'(r_rem[ST-1][1] > {{(MW-ST){1'b0}}, r_root[ST-1][1]});
            r_out_side <= r_side[ST-1];
        end
    end

    assign o_valid    = r_out_vld;
    assign o_side     = r_out_side;
    assign o_rad_root = r_out_rad;
    assign o_pol_root = r_out_pol;

endmodule

/* rtl/c2s_cordic.sv */
// two-lane vectoring rotation pipeline and output rounding
module c2s_cordic #(
    parameter int STEPS = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  c2s_pkg::t_side                i_side,
    input  logic [c2s_pkg::ROOT_W-1:0]    i_rad_root,
    input  logic [c2s_pkg::ROOT_W-1:0]    i_pol_root,
    output logic                          o_valid,
    output c2s_pkg::t_out                 o_data
);

    localparam int CW = c2s_pkg::CW;
    localparam int AW = c2s_pkg::ANG_W;
    localparam int OW = c2s_pkg::ROOT_W;
    localparam int CB = c2s_pkg::COORD_BITS;
    localparam int NB = c2s_pkg::ANGLE_BITS;
    localparam logic [AW-1:0] HALF     = {1'b1, {(AW-1){1'b0}}};
    localparam logic [AW-1:0] THREEQ   = {2'b11, {(AW-2){1'b0}}};
    localparam logic [AW:0]   RND      = (AW+1)'(1) << (AW - NB - 1);

    logic signed [CW-1:0] r_x [STEPS+1][2];
    logic signed [CW-1:0] r_y [STEPS+1][2];
    logic [AW-1:0]        r_a [STEPS+1][2];
    c2s_pkg::t_tail       r_tail [STEPS+1];
    logic [STEPS:0]       r_vld;

    c2s_pkg::t_out        r_out;
    logic                 r_out_vld;

    logic signed [CW-1:0] px [2];
    logic signed [CW-1:0] py [2];
    c2s_pkg::t_tail       n_tail;

    assign px[0] = i_side.az_x;
    assign py[0] = i_side.az_y;
    assign px[1] = i_side.pol_x;
    assign py[1] = {{(CW-OW){1'b0}}, i_pol_root};
    assign n_tail.radius     = i_rad_root[CB-1:0];
    assign n_tail.zero       = i_side.zero;
    assign n_tail.plane_zero = i_side.plane_zero;

    // fold the left half plane over before the rotations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                if (px[l][CW-1]) begin
                    r_x[0][l] <= -px[l];
                    r_y[0][l] <= -py[l];
                    r_a[0][l] <= HALF;
                end else begin
                    r_x[0][l] <= px[l];
                    r_y[0][l] <= py[l];
                    r_a[0][l] <= '0;
                end
            end
            r_tail[0] <= n_tail;
        end
    end

    genvar s, l;
    generate
        for (s = 0; s < STEPS; s++) begin : g_st
            localparam logic [AW-1:0] ANG = c2s_pkg::atan_turns(5'(s));
            for (l = 0; l < 2; l++) begin : g_lane
                logic signed [CW-1:0] dx, dy;
                assign dx = r_y[s][l] >>> s;
                assign dy = r_x[s][l] >>> s;
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        if (!r_y[s][l][CW-1]) begin
                            r_x[s+1][l] <= r_x[s][l] + dx;
                            r_y[s+1][l] <= r_y[s][l] - dy;
                            r_a[s+1][l] <= r_a[s][l] + ANG;
                        end else begin
                            r_x[s+1][l] <= r_x[s][l] - dx;
                            r_y[s+1][l] <= r_y[s][l] + dy;
                            r_a[s+1][l] <= r_a[s][l] - ANG;
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s+1] <= r_vld[s];
                end
                if (i_en) begin
                    r_tail[s+1] <= r_tail[s];
                end
            end
        end
    endgenerate

    logic [AW-1:0] pol_c;
    logic [AW:0]   az_r, pol_r;

    // rotation error can push the polar angle just outside zero to half a turn
    always_comb begin
        if (r_a[STEPS][1] >= THREEQ) begin
            pol_c = '0;
        end else if (r_a[STEPS][1] > HALF) begin
            pol_c = HALF;
        end else begin
            pol_c = r_a[STEPS][1];
        end
        az_r  = {1'b0, r_a[STEPS][0]} + RND;
        pol_r = {1'b0, pol_c} + RND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[STEPS];
        end
        if (i_en) begin
            r_out.radius      <= r_tail[STEPS].radius;
            r_out.azimuth     <= r_tail[STEPS].plane_zero ? '0 : az_r[AW-1 -: NB];
            r_out.polar_angle <= r_tail[STEPS].zero ? '0 : pol_r[AW-1 -: NB];
            r_out.zero_radius <= r_tail[STEPS].zero;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

/* rtl/cartesian_to_spherical.sv */
// top level of the cartesian to spherical converter
//
// Input channel i_valid / o_stall / i_data carries one point (x, y, z) per
// item; output channel o_valid / i_stall / o_data carries radius, azimuth,
// polar angle and the zero radius flag. An item moves when valid is high and
// stall is low at a rising edge.
// The pipeline holds six front stages for magnitudes, squares, sums and
// normalizing shifts, 30 root digit stages plus one rounding stage, then one
// fold stage, CORDIC_STEPS rotation stages and the output register.
// Throughput is one item per cycle unless i_stall holds the output; every stage
// is a register with its own valid bit and no stage is shared between items.
// While the output item is held by i_stall the whole pipeline freezes and
// o_stall is raised, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; the block keeps no other state.
module cartesian_to_spherical #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  c2s_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output c2s_pkg::t_out  o_data
);

    logic en;
    logic fr_valid, sq_valid;
    c2s_pkg::t_side fr_side, sq_side;
    logic [c2s_pkg::RAD_W-1:0]  fr_rad_n, fr_pol_n;
    logic [c2s_pkg::ROOT_W-1:0] sq_rad, sq_pol;

    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    c2s_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (fr_valid),
        .o_side  (fr_side),
        .o_rad_n (fr_rad_n),
        .o_pol_n (fr_pol_n)
    );

    c2s_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (fr_valid),
        .i_side     (fr_side),
        .i_rad_n    (fr_rad_n),
        .i_pol_n    (fr_pol_n),
        .o_valid    (sq_valid),
        .o_side     (sq_side),
        .o_rad_root (sq_rad),
        .o_pol_root (sq_pol)
    );

    c2s_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (sq_valid),
        .i_side     (sq_side),
        .i_rad_root (sq_rad),
        .i_pol_root (sq_pol),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

endmodule

/* rtl/c2s_checker.sv */
// port-level checks for the cartesian to spherical converter
module c2s_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input c2s_pkg::t_out o_data
);

    // origin gives all-zero angles and radius
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_radius |->
            o_data.radius == '0 && o_data.azimuth == '0 && o_data.polar_angle == '0)
        else $error("origin item with nonzero fields");

    // any point off the origin rounds to a radius of at least one
    a_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.zero_radius |-> o_data.radius != '0)
        else $error("zero radius without flag");

    a_polar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.polar_angle <= 16'h8000)
        else $error("polar angle beyond half a turn");

    // a held output item pushes back on the input side
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("output held without input stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled item changed");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

/* test/testbench.sv */
// testbench for the cartesian to spherical converter with its own prediction of each result
module testbench;

    localparam int STEPS    = 18;
    localparam int LATENCY  = 39 + STEPS;
    localparam int N_RANDOM = 500;

    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };
    localparam logic [31:0] HALF_TURN    = 32'h80000000;
    localparam logic [31:0] THREE_QUARTS = 32'hC0000000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    c2s_pkg::t_in   i_data;
    logic           o_valid;
    logic           i_stall;
    c2s_pkg::t_out  o_data;

    c2s_pkg::t_out pending_points[$];
    int    errors;
    bit    rx_idle_en;
    bit    tx_idle_en;
    int    rx_hold;

    cartesian_to_spherical #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("Test completed with failures");
        $finish;
    end

    // rounded integer square root
    function automatic logic [63:0] root_rounded(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        if (n > res) res = res + 1;
        return res;
    endfunction

    // pairs of bits that bring a nonzero magnitude into [2^58, 2^60)
    function automatic int pair_shift(input logic [63:0] m);
        int k;
        k = 0;
        while (m < (64'd1 << 58)) begin
            m = m << 2;
            k++;
        end
        return k;
    endfunction

    function automatic logic [31:0] vector_angle(input longint xv, input longint yv);
        logic [31:0] a;
        longint dx;
        longint dy;
        a = '0;
        if (xv < 0) begin
            xv = -xv;
            yv = -yv;
            a = HALF_TURN;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv = xv + dx;
                yv = yv - dy;
                a = a + ATAN_TURNS[i];
            end else begin
                xv = xv - dx;
                yv = yv + dy;
                a = a - ATAN_TURNS[i];
            end
        end
        return a;
    endfunction

    function automatic c2s_pkg::t_out spherical_of(input c2s_pkg::t_in p);
        c2s_pkg::t_out r;
        longint x;
        longint y;
        longint z;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] az;
        logic [63:0] plane;
        logic [63:0] zz;
        logic [63:0] wide;
        logic [31:0] a;
        int k;
        x = p.coord_x;
        y = p.coord_y;
        z = p.coord_z;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        plane = ax * ax + ay * ay;
        zz = az * az;
        r = '0;
        wide = root_rounded(plane + zz);
        r.radius = wide[c2s_pkg::COORD_BITS-1:0];
        if (plane == 0 && zz == 0) begin
            r.zero_radius = 1'b1;
        end else begin
            if (plane != 0) begin
                k = pair_shift(plane);
                a = vector_angle(x * (longint'(1) << k), y * (longint'(1) << k));
                wide = ({32'd0, a} + (64'd1 << (31 - c2s_pkg::ANGLE_BITS)))
                    >> (32 - c2s_pkg::ANGLE_BITS);
                r.azimuth = wide[c2s_pkg::ANGLE_BITS-1:0];
            end
            k = pair_shift(plane > zz ? plane : zz);
            a = vector_angle(z * (longint'(1) << k), longint'(root_rounded(plane << (2 * k))));
            if (a >= THREE_QUARTS) a = '0;
            else if (a > HALF_TURN) a = HALF_TURN;
            wide = ({32'd0, a} + (64'd1 << (31 - c2s_pkg::ANGLE_BITS)))
                >> (32 - c2s_pkg::ANGLE_BITS);
            r.polar_angle = wide[c2s_pkg::ANGLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one point, held until the block takes it
    task automatic send_point(input c2s_pkg::t_in p);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data = p;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        pending_points.push_back(spherical_of(p));
        @(negedge i_clk);
    endtask

    task automatic go_quiet();
        i_valid = 1'b0;
        wait (pending_points.size() == 0);
        @(negedge i_clk);
    endtask

    function automatic c2s_pkg::t_in make_point(input int sx, input int sy, input int sz);
        c2s_pkg::t_in p;
        p.coord_x = 24'(sx);
        p.coord_y = 24'(sy);
        p.coord_z = 24'(sz);
        return p;
    endfunction

    function automatic logic signed [23:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $signed(24'($urandom_range(0, 15))) - 8;
            2: return ($urandom_range(0, 1)) ? 24'sh7FFFFF - $urandom_range(0, 3)
                                             : 24'sh800000 + $urandom_range(0, 3);
            3: return $signed(24'($urandom_range(0, 8191))) - 4096;
            default: return 24'($urandom);
        endcase
    endfunction

    // receiver side: random stall, long hold when asked, checks each result
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_stall = 1'b1;
                rx_hold--;
            end else if (rx_idle_en) begin
                i_stall = ($urandom_range(0, 99) < 25) ||
                          (i_stall && $urandom_range(0, 99) < 70);
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    initial begin
        c2s_pkg::t_out want;
        logic [15:0] d16;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_points.size() == 0) begin
                    $display("%0t: unexpected item radius=%0d azimuth=%0d polar=%0d zero=%0b",
                             $time, o_data.radius, o_data.azimuth, o_data.polar_angle,
                             o_data.zero_radius);
                    errors++;
                end else begin
                    want = pending_points.pop_front();
                    if (o_data.radius > want.radius + 1 || want.radius > o_data.radius + 1) begin
                        $display("%0t: radius expected %0d actual %0d",
                                 $time, want.radius, o_data.radius);
                        errors++;
                    end
                    d16 = want.azimuth - o_data.azimuth;
                    if (d16 != 0 && d16 != 1 && d16 != 16'hFFFF) begin
                        $display("%0t: azimuth expected %0d actual %0d",
                                 $time, want.azimuth, o_data.azimuth);
                        errors++;
                    end
                    if (o_data.polar_angle > want.polar_angle + 1 ||
                        want.polar_angle > o_data.polar_angle + 1) begin
                        $display("%0t: polar angle expected %0d actual %0d",
                                 $time, want.polar_angle, o_data.polar_angle);
                        errors++;
                    end
                    if (o_data.zero_radius !== want.zero_radius) begin
                        $display("%0t: zero radius expected %0b actual %0b",
                                 $time, want.zero_radius, o_data.zero_radius);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        int m;
        m = -8388608;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_point(make_point(0, 0, 0));
        send_point(make_point(0, 0, 1));
        send_point(make_point(0, 0, -1));
        send_point(make_point(0, 0, m));
        send_point(make_point(0, 0, 8388607));
        send_point(make_point(1, 0, 0));
        send_point(make_point(-1, 0, 0));
        send_point(make_point(0, 1, 0));
        send_point(make_point(0, -1, 0));
        send_point(make_point(m, 0, 0));
        send_point(make_point(m, m, m));
        send_point(make_point(8388607, 8388607, 8388607));
        send_point(make_point(m, 8388607, m));
        send_point(make_point(8388607, -1, 0));   // azimuth rounds up to a full turn
        send_point(make_point(8388607, -1, 5));
        send_point(make_point(m, -1, 0));
        send_point(make_point(m, 1, 0));
        send_point(make_point(1, 1, 8388607));    // polar angle near zero
        send_point(make_point(1, 0, m));          // polar angle near half a turn
        send_point(make_point(-1, -1, -1));
        send_point(make_point(3, 4, 12));
        go_quiet();
    endtask

    task automatic test_random();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) tx_idle_en = 1'b0;
            if (i == N_RANDOM / 2) begin
                tx_idle_en = 1'b1;
                rx_idle_en = 1'b0;
            end
            if (i == 2 * N_RANDOM / 3) rx_idle_en = 1'b1;
            send_point(make_point(pick_coord(), pick_coord(), pick_coord()));
            if (i == N_RANDOM / 4) go_quiet();
        end
        go_quiet();
    endtask

    // output held long enough that the pipeline fills and pushes back
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_hold = 2 * LATENCY + 40;
        for (int i = 0; i < LATENCY + 30; i++)
            send_point(make_point(24'($urandom), 24'($urandom), 24'($urandom)));
        go_quiet();
    endtask

    initial begin
        errors = 0;
        rx_hold = 0;
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (errors == 0 && pending_points.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/c2s_pkg.sv
rtl/c2s_front.sv
rtl/c2s_sqrt.sv
rtl/c2s_cordic.sv
rtl/cartesian_to_spherical.sv
rtl/c2s_checker.sv
test/testbench.sv
